### rtl/cdq_pkg.sv
package cdq_pkg;

  // field widths
  localparam int CAP_W = 5;
  localparam int VAL_W = 32;
  localparam int REQ_W = 3;

  // largest capacity the register can express, and its reset value
  localparam int CAP_LIMIT = (2 ** CAP_W) - 1;
  localparam int CAP_RESET = 16;

  // request codes; the unused codes act as a status request
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_REAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STATUS    = 3'd4;

  // input item
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] value;
  } cdq_in_t;

  // result item
  typedef struct packed {
    logic                    accepted;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [CAP_W-1:0]        occupancy;
  } cdq_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // apply the item on the ports to the deque
    logic fetch;  // read front and rear entries into the output registers
  } cdq_cmd_t;

endpackage

### rtl/cdq_ctrl.sv
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output cdq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SHOW
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   valid_r;
  logic   fetch_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_SHOW;
      S_SHOW:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      fetch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      valid_r <= (state_nxt == S_SHOW);
      fetch_r <= (state_nxt == S_FETCH);
    end
  end

  // item accepted when idle and start is high
  assign cmd.exec  = start && !busy_r;
  assign cmd.fetch = fetch_r;
  assign busy      = busy_r;
  assign out_valid = valid_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_exec_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> busy && cmd.fetch && !out_valid)
    else $error("accepted item did not start a fetch");

  a_fetch_then_show: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |=> out_valid && busy)
    else $error("fetch not followed by result strobe");

endmodule

### rtl/cdq_datapath.sv
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cdq_cmd_t         cmd,
  input  cdq_in_t          in_item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output cdq_out_t         out_item
);

  // capacity never exceeds the ring size or what the register can hold
  localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam int IDX_W   = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
  localparam logic [CAP_W-1:0] CAP_RST_V =
    CAP_W'((CAP_MAX < CAP_RESET) ? CAP_MAX : CAP_RESET);

  // ring store
  logic [VAL_W-1:0] ring_mem [CAP_MAX];

  logic [CAP_W-1:0] cap_r,   cap_nxt;
  logic [IDX_W-1:0] head_r,  head_nxt;
  logic [IDX_W-1:0] tail_r,  tail_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;
  logic             ok_r,    ok_nxt;
  logic [VAL_W-1:0] front_r;
  logic [VAL_W-1:0] rear_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CAP_W-1:0] cap_in;
  logic             full;
  logic             empty;

  // index moves with compare and wrap
  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] nx;
    nx = CAP_W'(i) + CAP_W'(1);
    return (nx >= cap) ? '0 : IDX_W'(nx);
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    return (i == '0) ? IDX_W'(cap - CAP_W'(1)) : i - IDX_W'(1);
  endfunction

  // written capacity clamped to the legal range
  assign cap_in = (cfg_data == '0)       ? CAP_W'(1) :
                  (cfg_data > CAP_MAX_V) ? CAP_MAX_V : cfg_data;

  assign full  = (count_r >= cap_r);
  assign empty = (count_r == '0);

  // request decode and pointer update
  always_comb begin
    cap_nxt   = cap_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_idx    = head_r;
    if (cfg_we) begin
      cap_nxt   = cap_in;
      head_nxt  = '0;
      tail_nxt  = IDX_W'(cap_in - CAP_W'(1));
      count_nxt = '0;
    end else if (cmd.exec) begin
      ok_nxt = 1'b1;
      case (in_item.req_type)
        REQ_INS_FRONT: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            head_nxt  = step_down(head_r, cap_r);
            wr_en     = 1'b1;
            wr_idx    = head_nxt;
            count_nxt = count_r + CAP_W'(1);
          end
        end
        REQ_INS_REAR: begin
          if (full) begin
            ok_nxt = 1'b0;
          end else begin
            tail_nxt  = step_up(tail_r, cap_r);
            wr_en     = 1'b1;
            wr_idx    = tail_nxt;
            count_nxt = count_r + CAP_W'(1);
          end
        end
        REQ_DEL_FRONT: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            head_nxt  = step_up(head_r, cap_r);
            count_nxt = count_r - CAP_W'(1);
          end
        end
        REQ_DEL_REAR: begin
          if (empty) begin
            ok_nxt = 1'b0;
          end else begin
            tail_nxt  = step_down(tail_r, cap_r);
            count_nxt = count_r - CAP_W'(1);
          end
        end
        // status and unused codes leave the deque as it is
        default: ok_nxt = 1'b1;
      endcase
    end
  end

  // deque control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RST_V;
      head_r  <= '0;
      tail_r  <= IDX_W'(CAP_RST_V - CAP_W'(1));
      count_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // ring write and registered reads of front and rear
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_idx] <= in_item.value;
    end
    if (cmd.fetch) begin
      front_r <= ring_mem[head_r];
      rear_r  <= ring_mem[tail_r];
    end
  end

  // result item, -1 at both ends when empty
  assign out_item.accepted    = ok_r;
  assign out_item.front_value = empty ? '1 : front_r;
  assign out_item.rear_value  = empty ? '1 : rear_r;
  assign out_item.is_empty    = empty;
  assign out_item.is_full     = (count_r == cap_r);
  assign out_item.occupancy   = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count above capacity");

  a_cap_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r != '0 && cap_r <= CAP_MAX_V)
    else $error("capacity out of range");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(head_r) < cap_r && CAP_W'(tail_r) < cap_r)
    else $error("ring index beyond capacity");

endmodule

### rtl/circular_deque.sv
// channel   ports                          handshake
// input     in_item (req_type, value)      taken when start && !busy
// result    out_item (accepted .. occup.)  shown one cycle with out_valid
// config    cfg_we, cfg_data (capacity)    written when cfg_we, empties deque
//
// for each item, the accept edge updates the pointers and writes the ring,
// the next edge reads front and rear entries into registers, and the result
// is then shown with out_valid high
// busy stays high after accept until the result is shown, so a new item is
// taken only after the last result; the registered ring read needs S_FETCH
// synchronous reset gives an empty deque with capacity 16 (or DEPTH if less)
// the receiver cannot stall; a result is gone after its strobe cycle
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cdq_in_t          in_item,
  output logic             out_valid,
  output cdq_out_t         out_item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cdq_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int STALL_LIMIT = 1000;

  // request codes with no operation of their own, treated as status
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

  // deque predictor and store of expected results
  class deque_scoreboard;
    logic signed [VAL_W-1:0] ring [RING_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    int unsigned cap;
    cdq_out_t    pending [$];
    int          errors;

    function new();
      cap    = CAP_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      head  = 0;
      tail  = cap - 1;
      count = 0;
    endfunction

    // zero is taken as one, anything above the ring size as the ring size
    function void set_capacity(logic [CAP_W-1:0] v);
      if (v == 0) cap = 1;
      else if (v > RING_DEPTH) cap = RING_DEPTH;
      else cap = v;
      clear();
    endfunction

    function int unsigned wrap_up(int unsigned i);
      return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function int unsigned wrap_down(int unsigned i);
      return (i == 0) ? cap - 1 : i - 1;
    endfunction

    // apply one accepted item and queue the result it should give
    function void note_input(cdq_in_t it);
      cdq_out_t r;
      logic     ok;
      ok = 1'b1;
      case (it.req_type)
        REQ_INS_FRONT: begin
          if (count >= cap) ok = 1'b0;
          else begin
            head = wrap_down(head);
            ring[head] = it.value;
            count++;
          end
        end
        REQ_INS_REAR: begin
          if (count >= cap) ok = 1'b0;
          else begin
            tail = wrap_up(tail);
            ring[tail] = it.value;
            count++;
          end
        end
        REQ_DEL_FRONT: begin
          if (count == 0) ok = 1'b0;
          else begin
            head = wrap_up(head);
            count--;
          end
        end
        REQ_DEL_REAR: begin
          if (count == 0) ok = 1'b0;
          else begin
            tail = wrap_down(tail);
            count--;
          end
        end
        default: ;
      endcase
      r.accepted    = ok;
      r.front_value = (count == 0) ? '1 : ring[head];
      r.rear_value  = (count == 0) ? '1 : ring[tail];
      r.is_empty    = (count == 0);
      r.is_full     = (count == cap);
      r.occupancy   = CAP_W'(count);
      pending.push_back(r);
    endfunction

    // compare a result with the oldest expectation
    function void check_result(cdq_out_t got);
      cdq_out_t want;
      if (pending.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
        errors++;
      end
      if (got.rear_value !== want.rear_value) begin
        $error("rear_value: expected %0d, got %0d", want.rear_value, got.rear_value);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.is_full !== want.is_full) begin
        $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  cdq_in_t          in_item = '0;
  logic             out_valid;
  cdq_out_t         out_item;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;

  deque_scoreboard sb;
  bit              steady_send = 1'b0;
  int              stall_cycles = 0;

  always #5 clk = ~clk;

  circular_deque #(.DEPTH(RING_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // track capacity writes, accepted items and results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_capacity(cfg_data);
      if (start && busy === 1'b0) sb.note_input(in_item);
      if (out_valid === 1'b1) sb.check_result(out_item);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one item, sometimes after a random gap, and hold it until taken
  task automatic drive_item(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val);
    if (!steady_send && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cdq_in_t'{req_type: req, value: val};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] pick_status();
    case ($urandom_range(3))
      0: return REQ_SPARE_A;
      1: return REQ_SPARE_B;
      2: return REQ_SPARE_C;
      default: return REQ_STATUS;
    endcase
  endfunction

  // alternate fill and drain runs so full and empty are both reached often
  task automatic run_random_phase(input int n_items);
    bit               filling;
    int               run_left;
    int               r;
    logic [REQ_W-1:0] req;
    filling  = 1'b0;
    run_left = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        filling  = ~filling;
        run_left = $urandom_range(sb.cap, 3 * sb.cap + 2);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 8) req = pick_status();
      else if ((r < 70) == filling) req = $urandom_range(1) ? REQ_INS_FRONT : REQ_INS_REAR;
      else req = $urandom_range(1) ? REQ_DEL_FRONT : REQ_DEL_REAR;
      drive_item(req, pick_value());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_cap [12];
    sb = new();
    phase_cap = '{5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd5,
                  5'd16, 5'd3, 5'd8, 5'd0, 5'd12, 5'd31};

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // empty deque at reset capacity: status, refused deletes, spare codes
    drive_item(REQ_STATUS, pick_value());
    drive_item(REQ_DEL_FRONT, pick_value());
    drive_item(REQ_DEL_REAR, pick_value());
    drive_item(REQ_SPARE_A, pick_value());
    drive_item(REQ_SPARE_B, pick_value());
    drive_item(REQ_SPARE_C, pick_value());

    // value extremes at both ends, then empty it again
    drive_item(REQ_INS_FRONT, 32'h7FFF_FFFF);
    drive_item(REQ_INS_REAR, 32'h8000_0000);
    drive_item(REQ_INS_FRONT, 32'hFFFF_FFFF);
    drive_item(REQ_INS_REAR, 32'h0000_0000);
    drive_item(REQ_STATUS, pick_value());
    drive_item(REQ_DEL_FRONT, pick_value());
    drive_item(REQ_DEL_REAR, pick_value());
    drive_item(REQ_DEL_FRONT, pick_value());
    drive_item(REQ_DEL_REAR, pick_value());

    // capacity written as zero acts as one: refused inserts when full
    write_capacity('0);
    drive_item(REQ_INS_REAR, 32'h5A5A_5A5A);
    drive_item(REQ_INS_FRONT, 32'hA5A5_A5A5);
    drive_item(REQ_INS_REAR, 32'h1234_5678);
    drive_item(REQ_DEL_FRONT, pick_value());
    drive_item(REQ_DEL_REAR, pick_value());

    // random phases over a spread of capacities
    for (int p = 0; p < 12; p++) begin
      write_capacity(p == 11 ? CAP_W'($urandom_range(0, 31)) : phase_cap[p]);
      steady_send = (p == 6 || p == 7);
      run_random_phase(100);
    end
    steady_send = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### circular_deque.f
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque.sv
tb/sv/tb_top.sv
